/* src/tscf_pkg.sv */
// tscf_pkg: shared types and constants for the touch sample calibrate filter
// no dependencies; imported by tscf_axis and touch_sample_calibrate_filter_unit
`default_nettype none

package tscf_pkg;

	// configuration port geometry
	localparam int CFG_W = 32;
	localparam int CFG_IDX_W = 3;

	// raw coordinate is wrapped to 16 bits before calibration
	localparam int RAW_W = 16;
	// signed Q16.16 gain times unsigned raw
	localparam int PROD_W = 48;
	// product plus offset
	localparam int SUM_W = 49;
	// fraction bits of the calibration format
	localparam int FRAC_W = 16;
	// clamp ceiling width and calibrated coordinate width
	localparam int LIM_W = 12;
	// held coordinates cover -1 .. 4095
	localparam int HELD_W = 13;
	// movement deadband width
	localparam int THR_W = 8;
	// distance between two held coordinates
	localparam int DIST_W = 14;

	// register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GAIN_X    = 3'd0,
		CFG_OFFSET_X  = 3'd1,
		CFG_GAIN_Y    = 3'd2,
		CFG_OFFSET_Y  = 3'd3,
		CFG_LIMIT_X   = 3'd4,
		CFG_LIMIT_Y   = 3'd5,
		CFG_THRESHOLD = 3'd6
	} cfg_idx_t;

	// calibration settings of one axis
	typedef struct packed {
		logic signed [CFG_W-1:0] gain;
		logic signed [CFG_W-1:0] offset;
		logic [LIM_W-1:0]        limit;
	} axis_cfg_t;

	// register reset values
	localparam logic signed [CFG_W-1:0] GAIN_X_RST   = 32'sd13625;
	localparam logic signed [CFG_W-1:0] OFFSET_X_RST = -32'sd1819607;
	localparam logic signed [CFG_W-1:0] GAIN_Y_RST   = -32'sd8402;
	localparam logic signed [CFG_W-1:0] OFFSET_Y_RST = 32'sd32504073;
	localparam logic [LIM_W-1:0]        LIMIT_X_RST  = 12'd799;
	localparam logic [LIM_W-1:0]        LIMIT_Y_RST  = 12'd479;
	localparam logic [THR_W-1:0]        THR_RST      = 8'd3;

	// coordinate reported while idle
	localparam logic signed [HELD_W-1:0] COORD_IDLE = '1;

endpackage

`default_nettype wire

/* src/tscf_axis.sv */
// tscf_axis: raw coordinate, linear calibration and clamp for one axis
// depends on tscf_pkg; two-stage pipeline (product register, coordinate register)
`default_nettype none

module tscf_axis
	import tscf_pkg::*;
#(
	parameter int SAMPLE_BITS = 12
) (
	input  wire                     clk,
	input  wire                     adv,
	input  wire [SAMPLE_BITS-1:0]   first_s1,
	input  wire [SAMPLE_BITS-1:0]   second_s1,
	input  axis_cfg_t               cfg,
	output logic [LIM_W-1:0]        coord_s3
);

	logic signed [RAW_W:0]    first_ext;
	logic signed [RAW_W:0]    diff;
	logic signed [RAW_W:0]    half;
	logic [RAW_W-1:0]         raw;
	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [SUM_W-1:0]  sum;
	logic signed [SUM_W-1:0]  ceil_q16;
	logic [LIM_W-1:0]         coord;

	// first plus half the difference, wrapped to 16 bits
	always_comb begin
		first_ext = $signed((RAW_W+1)'(first_s1));
		diff = first_ext - $signed((RAW_W+1)'(second_s1));
		half = diff >>> 1;
		raw = RAW_W'(first_ext + half);
	end

	// gain times raw, raw taken as unsigned
	assign prod = cfg.gain * $signed({1'b0, raw});

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2 <= prod;
		end
	end

	// add offset, clamp to 1 .. limit, drop the fraction
	always_comb begin
		sum = SUM_W'(prod_s2) + SUM_W'(cfg.offset);
		ceil_q16 = $signed(SUM_W'({cfg.limit, {FRAC_W{1'b0}}}));
		if (sum <= $signed(SUM_W'(1 << FRAC_W))) begin
			coord = LIM_W'(1);
		end else if (sum >= ceil_q16) begin
			coord = cfg.limit;
		end else begin
			coord = sum[FRAC_W+LIM_W-1:FRAC_W];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			coord_s3 <= coord;
		end
	end

endmodule

`default_nettype wire

/* src/touch_sample_calibrate_filter_unit.sv */
// Touch sample calibrate filter: one poll sample per request in, at most one touch
// event out. Each axis forms first + ((first - second) >>> 1), applies gain*raw + offset
// in signed Q16.16 and clamps to 1..limit; idle samples after idle report -1,-1, a release
// reports the last held position. Events come on press, release, a held touch moving
// beyond move_threshold on either axis, and every idle sample. A request is taken every
// cycle unless a waiting event is stalled. A taken request lands in the input register,
// then moves through the product register, the coordinate register and the event register.
// The depth is set by the one multiplier per axis and the offset add and clamp after it.
// Depends on tscf_pkg and tscf_axis.
`default_nettype none

module touch_sample_calibrate_filter_unit
	import tscf_pkg::*;
#(
	parameter int SAMPLE_BITS = 12,
	parameter int COORD_BITS  = 13
) (
	input  wire                          clk,
	input  wire                          arst_n,
	// configuration
	input  wire                          cfg_we,
	input  wire [CFG_IDX_W-1:0]          cfg_index,
	input  wire [CFG_W-1:0]              cfg_wdata,
	// sample requests
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire                          touched,
	input  wire [SAMPLE_BITS-1:0]        x_first,
	input  wire [SAMPLE_BITS-1:0]        x_second,
	input  wire [SAMPLE_BITS-1:0]        y_first,
	input  wire [SAMPLE_BITS-1:0]        y_second,
	// touch events
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic                         pressed,
	output logic signed [COORD_BITS-1:0] pos_x,
	output logic signed [COORD_BITS-1:0] pos_y
);

	axis_cfg_t              cfg_x_q;
	axis_cfg_t              cfg_y_q;
	logic [THR_W-1:0]       thr_q;

	logic                   adv;
	logic                   v_s1, v_s2, v_s3;
	logic                   tch_s1, tch_s2, tch_s3;
	logic [SAMPLE_BITS-1:0] x_first_s1, x_second_s1, y_first_s1, y_second_s1;
	logic [LIM_W-1:0]       cx_s3, cy_s3;

	logic                   was_q;
	logic signed [HELD_W-1:0] held_x_q, held_y_q;
	logic                   was_n;
	logic signed [HELD_W-1:0] held_x_n, held_y_n;
	logic signed [HELD_W-1:0] px, py;
	logic signed [DIST_W-1:0] dx, dy;
	logic [DIST_W-1:0]      adx, ady;
	logic                   evt;

	logic                   out_valid_q;
	logic                   pressed_q;
	logic signed [HELD_W-1:0] pos_x_q, pos_y_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_x_q.gain   <= GAIN_X_RST;
			cfg_x_q.offset <= OFFSET_X_RST;
			cfg_x_q.limit  <= LIMIT_X_RST;
			cfg_y_q.gain   <= GAIN_Y_RST;
			cfg_y_q.offset <= OFFSET_Y_RST;
			cfg_y_q.limit  <= LIMIT_Y_RST;
			thr_q          <= THR_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_GAIN_X:    cfg_x_q.gain   <= $signed(cfg_wdata);
				CFG_OFFSET_X:  cfg_x_q.offset <= $signed(cfg_wdata);
				CFG_GAIN_Y:    cfg_y_q.gain   <= $signed(cfg_wdata);
				CFG_OFFSET_Y:  cfg_y_q.offset <= $signed(cfg_wdata);
				CFG_LIMIT_X:   cfg_x_q.limit  <= cfg_wdata[LIM_W-1:0];
				CFG_LIMIT_Y:   cfg_y_q.limit  <= cfg_wdata[LIM_W-1:0];
				CFG_THRESHOLD: thr_q          <= cfg_wdata[THR_W-1:0];
				default: ;
			endcase
		end
	end

	// whole pipeline moves unless a waiting event is stalled
	assign adv = !out_valid_q || !out_stall;
	assign in_stall = !adv;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// input register and touch flag stages
	always_ff @(posedge clk) begin
		if (adv) begin
			tch_s1      <= touched;
			x_first_s1  <= x_first;
			x_second_s1 <= x_second;
			y_first_s1  <= y_first;
			y_second_s1 <= y_second;
			tch_s2      <= tch_s1;
			tch_s3      <= tch_s2;
		end
	end

	// calibration per axis
	tscf_axis #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_axis_x (
		.clk      (clk),
		.adv      (adv),
		.first_s1 (x_first_s1),
		.second_s1(x_second_s1),
		.cfg      (cfg_x_q),
		.coord_s3 (cx_s3)
	);

	tscf_axis #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_axis_y (
		.clk      (clk),
		.adv      (adv),
		.first_s1 (y_first_s1),
		.second_s1(y_second_s1),
		.cfg      (cfg_y_q),
		.coord_s3 (cy_s3)
	);

	// event filter against the held state
	always_comb begin
		px = tch_s3 ? $signed({1'b0, cx_s3}) : COORD_IDLE;
		py = tch_s3 ? $signed({1'b0, cy_s3}) : COORD_IDLE;
		dx = DIST_W'(held_x_q) - DIST_W'(px);
		dy = DIST_W'(held_y_q) - DIST_W'(py);
		adx = dx[DIST_W-1] ? DIST_W'(-dx) : DIST_W'(dx);
		ady = dy[DIST_W-1] ? DIST_W'(-dy) : DIST_W'(dy);
		was_n = was_q;
		held_x_n = held_x_q;
		held_y_n = held_y_q;
		evt = 1'b1;
		if (was_q != tch_s3) begin
			was_n = tch_s3;
			if (tch_s3) begin
				held_x_n = px;
				held_y_n = py;
			end
		end else if (tch_s3) begin
			if (adx <= DIST_W'(thr_q) && ady <= DIST_W'(thr_q)) begin
				evt = 1'b0;
			end else begin
				held_x_n = px;
				held_y_n = py;
			end
		end else begin
			held_x_n = COORD_IDLE;
			held_y_n = COORD_IDLE;
		end
	end

	// held state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			was_q    <= 1'b0;
			held_x_q <= '0;
			held_y_q <= '0;
		end else if (adv && v_s3) begin
			was_q    <= was_n;
			held_x_q <= held_x_n;
			held_y_q <= held_y_n;
		end
	end

	// event register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_s3 && evt;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s3 && evt) begin
			pressed_q <= tch_s3;
			pos_x_q   <= held_x_n;
			pos_y_q   <= held_y_n;
		end
	end

	assign out_valid = out_valid_q;
	assign pressed   = pressed_q;
	assign pos_x     = COORD_BITS'(pos_x_q);
	assign pos_y     = COORD_BITS'(pos_y_q);

`ifndef SYNTHESIS
	// a waiting event always matches the held state
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (pressed_q == was_q && pos_x_q == held_x_q && pos_y_q == held_y_q))
	else $error("waiting event differs from held state");

	// an idle sample after idle reports -1,-1
	assert property (@(posedge clk) disable iff (!arst_n)
		(adv && v_s3 && !tch_s3 && !was_q) |=>
		(out_valid_q && !pressed_q && pos_x_q == COORD_IDLE && pos_y_q == COORD_IDLE))
	else $error("idle sample did not report idle position");

	// while pressed, held coordinates are never negative
	assert property (@(posedge clk) disable iff (!arst_n)
		was_q |-> (!held_x_q[HELD_W-1] && !held_y_q[HELD_W-1]))
	else $error("negative held coordinate while pressed");
`endif

endmodule

`default_nettype wire
